@@ design/pie_pkg.sv @@
package pie_pkg;

  localparam int SLOT_TABLE_DEPTH_DEF = 256;
  localparam int MAX_EXPANSION_DEF    = 8;

  localparam int SCALE_W = 7;
  localparam int EXP_W   = 4;
  localparam int OFF_W   = 6;
  localparam int PAGES_W = 7;
  localparam int ORD_W   = 16;
  localparam int BASE_W  = 25;
  localparam int ADDR_W  = 8;
  localparam int SLOT_W  = 24;
  localparam int PAGE_W  = 34;

  // The scratch position is (ordinal - begin) * pages, 23 bits, padded to a
  // whole number of divider steps.
  localparam int POS_W      = 24;
  localparam int REM_W      = 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = POS_W / DIV_STEPS;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_SCALE          = 3'd0;
  localparam logic [2:0] REG_EXPANSION      = 3'd1;
  localparam logic [2:0] REG_LAYER_OFFSET   = 3'd2;
  localparam logic [2:0] REG_SCRATCH_PAGES  = 3'd3;
  localparam logic [2:0] REG_PER_LAYER_MODE = 3'd4;
  localparam logic [2:0] REG_SCRATCH_ENABLE = 3'd5;
  localparam logic [2:0] REG_SCRATCH_BEGIN  = 3'd6;
  localparam logic [2:0] REG_SCRATCH_END    = 3'd7;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Item as it moves through the divider stages. num starts as the scratch
  // position and leaves as the quotient.
  typedef struct packed {
    logic              func;
    logic              in_scr;
    logic [ADDR_W-1:0] slot_addr;
    logic [SLOT_W-1:0] slot_value;
    logic              base_bad;
    logic [PAGE_W-1:0] lin_prod;
    logic [POS_W-1:0]  num;
    logic [REM_W-1:0]  rem;
  } item_t;

  // Finished block index handed to the output serializer.
  typedef struct packed {
    logic              func;
    logic              bad;
    logic              fault;
    logic [PAGE_W-1:0] idx;
  } res_t;

  // A few steps of restoring division. Returns {remainder, quotient bits}.
  function automatic logic [REM_W+DIV_STEPS-1:0] div_step(
    input logic [REM_W-1:0]     rem_in,
    input logic [DIV_STEPS-1:0] bits,
    input logic [SCALE_W-1:0]   dvs
  );
    logic [REM_W-1:0]     r;
    logic [REM_W:0]       t;
    logic [DIV_STEPS-1:0] q;
    r = rem_in;
    q = '0;
    for (int k = DIV_STEPS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= (REM_W+1)'(dvs)) begin
        t    = t - (REM_W+1)'(dvs);
        q[k] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
    return {r, q};
  endfunction

endpackage

@@ design/pie_ram.sv @@
module pie_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pie_div.sv @@
module pie_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [pie_pkg::SCALE_W-1:0]  sc,
  input  logic                         in_valid,
  input  pie_pkg::item_t               in_item,
  output logic                         out_valid,
  output pie_pkg::item_t               out_item
);

  localparam int N = pie_pkg::DIV_STAGES;
  localparam int S = pie_pkg::DIV_STEPS;
  localparam int P = pie_pkg::POS_W;
  localparam int R = pie_pkg::REM_W;

  logic [N-1:0]   valid_r;
  pie_pkg::item_t stg_r   [N];
  pie_pkg::item_t stg_nxt [N];

  // Each stage eats the top bits of num and shifts quotient bits in below.
  always_comb begin
    pie_pkg::item_t      src;
    logic [R+S-1:0]      res;
    for (int k = 0; k < N; k++) begin
      src         = (k == 0) ? in_item : stg_r[(k == 0) ? 0 : k - 1];
      res         = pie_pkg::div_step(src.rem, src.num[P-1 -: S], sc);
      stg_nxt[k]     = src;
      stg_nxt[k].num = {src.num[P-S-1:0], res[S-1:0]};
      stg_nxt[k].rem = res[R+S-1:S];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_item  = stg_r[N-1];

endmodule

@@ design/pie_tail.sv @@
module pie_tail #(
  parameter int SLOT_TABLE_DEPTH = pie_pkg::SLOT_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [pie_pkg::SCALE_W-1:0] sc,
  input  logic [pie_pkg::OFF_W-1:0]   off,
  input  logic                        in_valid,
  input  pie_pkg::item_t              in_item,
  output logic                        out_valid,
  output pie_pkg::res_t               out_res
);

  localparam int AW = (SLOT_TABLE_DEPTH > 1) ? $clog2(SLOT_TABLE_DEPTH) : 1;
  localparam int PW = pie_pkg::PAGE_W;
  localparam int RW = pie_pkg::REM_W;
  localparam int SW = pie_pkg::DIV_STEPS;

  // Slot table access. Writes and reads happen at the same stage so that
  // they keep the order in which their items arrived.
  logic                      fault;
  logic                      ram_we;
  logic                      ram_re;
  logic [pie_pkg::SLOT_W-1:0] ram_rdata;

  assign fault  = in_item.in_scr &&
                  (in_item.num >= pie_pkg::POS_W'(SLOT_TABLE_DEPTH));
  assign ram_we = adv && in_valid && (in_item.func == pie_pkg::FUNC_WRITE) &&
                  (32'(in_item.slot_addr) < 32'(SLOT_TABLE_DEPTH));
  assign ram_re = adv && in_valid && (in_item.func == pie_pkg::FUNC_CONVERT) &&
                  in_item.in_scr && !fault;

  pie_ram #(
    .WIDTH (pie_pkg::SLOT_W),
    .DEPTH (SLOT_TABLE_DEPTH)
  ) u_slot_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_item.slot_addr)),
    .wdata (in_item.slot_value),
    .re    (ram_re),
    .raddr (in_item.num[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Stage 1: offsets added, table read in flight.
  logic          v1_r, func1_r, scr1_r, fault1_r, bad1_r;
  logic [RW-1:0] r2_1_r;
  logic [PW-1:0] lin1_r;
  logic [PW-1:0] lin_sum;

  assign lin_sum = in_item.lin_prod + PW'(off);

  // Stage 2: slot id times scale, first half of the wrap of the remainder.
  logic          v2_r, func2_r, scr2_r, fault2_r, bad2_r;
  logic [RW-1:0] rm2_r;
  logic [SW-1:0] r2lo2_r;
  logic [PW-1:0] lin2_r, prod2_r;
  logic [RW+SW-1:0] mod_a;

  assign mod_a = pie_pkg::div_step('0, r2_1_r[RW-1:SW], sc);

  // Stage 3: second half of the wrap.
  logic          v3_r, func3_r, scr3_r, fault3_r, bad3_r;
  logic [RW-1:0] rm3_r;
  logic [PW-1:0] lin3_r, prod3_r;
  logic [RW+SW-1:0] mod_b;

  assign mod_b = pie_pkg::div_step(rm2_r, r2lo2_r, sc);

  // Stage 4: index selected.
  logic          v4_r;
  pie_pkg::res_t res4_r;
  pie_pkg::res_t res4_nxt;

  always_comb begin
    res4_nxt.func  = func3_r;
    res4_nxt.fault = fault3_r;
    res4_nxt.bad   = !scr3_r && bad3_r;
    if (fault3_r) begin
      res4_nxt.idx = '0;
    end else if (scr3_r) begin
      res4_nxt.idx = prod3_r + PW'(rm3_r);
    end else begin
      res4_nxt.idx = lin3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1_r  <= in_item.func;
      scr1_r   <= in_item.in_scr;
      fault1_r <= fault;
      bad1_r   <= in_item.base_bad || (lin_sum == '1);
      r2_1_r   <= in_item.rem + RW'(off);
      lin1_r   <= lin_sum;

      func2_r  <= func1_r;
      scr2_r   <= scr1_r;
      fault2_r <= fault1_r;
      bad2_r   <= bad1_r;
      rm2_r    <= mod_a[RW+SW-1:SW];
      r2lo2_r  <= r2_1_r[SW-1:0];
      lin2_r   <= lin1_r;
      prod2_r  <= PW'(ram_rdata) * PW'(sc);

      func3_r  <= func2_r;
      scr3_r   <= scr2_r;
      fault3_r <= fault2_r;
      bad3_r   <= bad2_r;
      rm3_r    <= mod_b[RW+SW-1:SW];
      lin3_r   <= lin2_r;
      prod3_r  <= prod2_r;

      res4_r   <= res4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_res   = res4_r;

endmodule

@@ design/pie_expand.sv @@
module pie_expand (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pie_pkg::EXP_W-1:0]         ex,
  input  logic                              in_valid,
  input  pie_pkg::res_t                     in_res,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pie_pkg::PAGE_W-1:0] out_page_index,
  output logic                              out_is_bad,
  output logic                              out_table_fault,
  output logic                              out_last
);

  localparam int PW = pie_pkg::PAGE_W;
  localparam int EW = pie_pkg::EXP_W;

  logic          valid_r, valid_nxt;
  logic [EW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          bad_r, bad_nxt;
  logic          fault_r, fault_nxt;
  logic          last_r, last_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [PW+EW-1:0] mul_full;
  logic          take;

  // A new block may load while the final result of the previous one leaves.
  assign in_ready = !valid_r || (out_ready && last_r);
  assign take     = in_valid && in_ready;
  assign mul_full = in_res.idx * ex;
  assign cnt_inc  = cnt_r + EW'(1);

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    bad_nxt   = bad_r;
    fault_nxt = fault_r;
    last_nxt  = last_r;
    page_nxt  = page_r;
    if (take) begin
      valid_nxt = 1'b1;
      cnt_nxt   = '0;
      prod_nxt  = mul_full[PW-1:0];
      bad_nxt   = in_res.bad;
      fault_nxt = in_res.fault;
      last_nxt  = (ex == EW'(1));
      if (in_res.bad) begin
        page_nxt = '1;
      end else if (in_res.fault) begin
        page_nxt = '0;
      end else begin
        page_nxt = mul_full[PW-1:0];
      end
    end else if (valid_r && out_ready) begin
      if (last_r) begin
        valid_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_inc;
        last_nxt = (cnt_inc == ex - EW'(1));
        if (bad_r) begin
          page_nxt = '1;
        end else if (fault_r) begin
          page_nxt = '0;
        end else begin
          page_nxt = prod_r + PW'(cnt_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    bad_r   <= bad_nxt;
    fault_r <= fault_nxt;
    last_r  <= last_nxt;
    page_r  <= page_nxt;
  end

  assign out_valid       = valid_r;
  assign out_page_index  = $signed(page_r);
  assign out_is_bad      = bad_r;
  assign out_table_fault = fault_r;
  assign out_last        = last_r;

endmodule

@@ design/page_index_expander.sv @@
// Page index expander. Write items (func 0) load one slot table entry and
// give no result; convert items (func 1) give expansion results each, the
// final one marked by last. Every item enters a pipeline of twelve stages
// (two input stages, six divider stages of four quotient bits each, four
// index stages), so an item is accepted in every cycle unless the serializer
// cannot take the convert item at its end. The first result of a convert
// item is offered once the serializer has loaded it from the last index
// stage. The output serializer delivers one result per cycle while out_ready
// is high, so a convert item holds the output until its expansion results
// (1 to MAX_EXPANSION) have left. The slot table is a SLOT_TABLE_DEPTH by 24
// bit memory with no clearing after reset; entries must be written before a
// scratch block reads them. The user must write registers through the APB
// port only while the block is idle; the block does not enforce this.
module page_index_expander #(
  parameter int SLOT_TABLE_DEPTH = pie_pkg::SLOT_TABLE_DEPTH_DEF,
  parameter int MAX_EXPANSION    = pie_pkg::MAX_EXPANSION_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [pie_pkg::ORD_W-1:0]         in_block_ordinal,
  input  logic signed [pie_pkg::BASE_W-1:0] in_base_index,
  input  logic [pie_pkg::ADDR_W-1:0]        in_slot_addr,
  input  logic [pie_pkg::SLOT_W-1:0]        in_slot_value,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pie_pkg::PAGE_W-1:0] out_page_index,
  output logic                              out_is_bad,
  output logic                              out_table_fault,
  output logic                              out_last,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pie_pkg::CFG_AW-1:0]        paddr,
  input  logic [pie_pkg::CFG_DW-1:0]        pwdata,
  output logic [pie_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int DW = pie_pkg::CFG_DW;
  localparam int EW = pie_pkg::EXP_W;

  // Configuration registers.
  logic [pie_pkg::SCALE_W-1:0] scale_r;
  logic [EW-1:0]               expansion_r;
  logic [pie_pkg::OFF_W-1:0]   layer_offset_r;
  logic [pie_pkg::PAGES_W-1:0] scratch_pages_r;
  logic                        per_layer_mode_r;
  logic                        scratch_enable_r;
  logic [pie_pkg::ORD_W-1:0]   scratch_begin_r;
  logic [pie_pkg::ORD_W-1:0]   scratch_end_r;
  logic [2:0]                  reg_idx;
  logic                        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r          <= pie_pkg::SCALE_W'(1);
      expansion_r      <= EW'(1);
      layer_offset_r   <= '0;
      scratch_pages_r  <= '0;
      per_layer_mode_r <= 1'b0;
      scratch_enable_r <= 1'b0;
      scratch_begin_r  <= '0;
      scratch_end_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pie_pkg::REG_SCALE:          scale_r          <= pwdata[pie_pkg::SCALE_W-1:0];
        pie_pkg::REG_EXPANSION:      expansion_r      <= pwdata[EW-1:0];
        pie_pkg::REG_LAYER_OFFSET:   layer_offset_r   <= pwdata[pie_pkg::OFF_W-1:0];
        pie_pkg::REG_SCRATCH_PAGES:  scratch_pages_r  <= pwdata[pie_pkg::PAGES_W-1:0];
        pie_pkg::REG_PER_LAYER_MODE: per_layer_mode_r <= pwdata[0];
        pie_pkg::REG_SCRATCH_ENABLE: scratch_enable_r <= pwdata[0];
        pie_pkg::REG_SCRATCH_BEGIN:  scratch_begin_r  <= pwdata[pie_pkg::ORD_W-1:0];
        pie_pkg::REG_SCRATCH_END:    scratch_end_r    <= pwdata[pie_pkg::ORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pie_pkg::REG_SCALE:          prdata = DW'(scale_r);
      pie_pkg::REG_EXPANSION:      prdata = DW'(expansion_r);
      pie_pkg::REG_LAYER_OFFSET:   prdata = DW'(layer_offset_r);
      pie_pkg::REG_SCRATCH_PAGES:  prdata = DW'(scratch_pages_r);
      pie_pkg::REG_PER_LAYER_MODE: prdata = DW'(per_layer_mode_r);
      pie_pkg::REG_SCRATCH_ENABLE: prdata = DW'(scratch_enable_r);
      pie_pkg::REG_SCRATCH_BEGIN:  prdata = DW'(scratch_begin_r);
      pie_pkg::REG_SCRATCH_END:    prdata = DW'(scratch_end_r);
      default:                     prdata = '0;
    endcase
  end

  // Effective settings: zero scale acts as one, the layer offset is used only in per-layer mode, expansion is clamped.
  logic [pie_pkg::SCALE_W-1:0] sc;
  logic [pie_pkg::OFF_W-1:0]   off;
  logic [EW-1:0]               exe;

  assign sc  = (scale_r == '0) ? pie_pkg::SCALE_W'(1) : scale_r;
  assign off = per_layer_mode_r ? layer_offset_r : '0;

  always_comb begin
    if (expansion_r == '0) begin
      exe = EW'(1);
    end else if (32'(expansion_r) > 32'(MAX_EXPANSION)) begin
      exe = EW'(MAX_EXPANSION);
    end else begin
      exe = expansion_r;
    end
  end

  // The whole pipeline moves together; it halts only while the serializer
  // cannot take the convert item at its end.
  logic          adv;
  logic          tail_valid;
  pie_pkg::res_t tail_res;
  logic          exp_ready;

  assign adv      = !tail_valid || (tail_res.func == pie_pkg::FUNC_WRITE) || exp_ready;
  assign in_ready = adv;

  // Stage 0: capture, range check.
  logic                              v0_r;
  logic                              func0_r;
  logic                              scr0_r;
  logic [pie_pkg::ORD_W-1:0]         diff0_r;
  logic signed [pie_pkg::BASE_W-1:0] base0_r;
  logic [pie_pkg::ADDR_W-1:0]        addr0_r;
  logic [pie_pkg::SLOT_W-1:0]        val0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func0_r <= in_func;
      scr0_r  <= scratch_enable_r && (in_block_ordinal >= scratch_begin_r) &&
                 (in_block_ordinal < scratch_end_r);
      diff0_r <= in_block_ordinal - scratch_begin_r;
      base0_r <= in_base_index;
      addr0_r <= in_slot_addr;
      val0_r  <= in_slot_value;
    end
  end

  // Stage 1: scratch position and linear product.
  logic                        v1_r;
  pie_pkg::item_t              s1_r;
  logic [pie_pkg::POS_W-1:0]   pos;
  logic signed [pie_pkg::BASE_W+pie_pkg::SCALE_W:0] lin_mul;

  assign pos     = pie_pkg::POS_W'(diff0_r) * pie_pkg::POS_W'(scratch_pages_r);
  assign lin_mul = base0_r * $signed({1'b0, sc});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.func       <= func0_r;
      s1_r.in_scr     <= scr0_r;
      s1_r.slot_addr  <= addr0_r;
      s1_r.slot_value <= val0_r;
      s1_r.base_bad   <= (base0_r == '1);
      s1_r.lin_prod   <= {lin_mul[pie_pkg::BASE_W+pie_pkg::SCALE_W], lin_mul};
      s1_r.num        <= pos;
      s1_r.rem        <= '0;
    end
  end

  logic           div_valid;
  pie_pkg::item_t div_item;

  pie_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sc        (sc),
    .in_valid  (v1_r),
    .in_item   (s1_r),
    .out_valid (div_valid),
    .out_item  (div_item)
  );

  pie_tail #(
    .SLOT_TABLE_DEPTH (SLOT_TABLE_DEPTH)
  ) u_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .sc        (sc),
    .off       (off),
    .in_valid  (div_valid),
    .in_item   (div_item),
    .out_valid (tail_valid),
    .out_res   (tail_res)
  );

  pie_expand u_expand (
    .clk             (clk),
    .rst_n           (rst_n),
    .ex              (exe),
    .in_valid        (tail_valid && (tail_res.func == pie_pkg::FUNC_CONVERT)),
    .in_res          (tail_res),
    .in_ready        (exp_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_page_index  (out_page_index),
    .out_is_bad      (out_is_bad),
    .out_table_fault (out_table_fault),
    .out_last        (out_last)
  );

`ifndef ASSERT_OFF
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_fault |-> (out_page_index == '0) && !out_is_bad)
    else $error("table fault result carries a nonzero index or bad flag");

  a_bad_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_bad |-> (out_page_index == '1))
    else $error("bad page result is not the sentinel");

  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("results of a block stopped before the last one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && tail_valid)
    else $error("input stalled without a pending result");
`endif

endmodule
